### rtl/core/sps_pkg.sv
package sps_pkg;

  // Configuration register geometry
  localparam int CFG_W = 16;
  localparam int IDX_W = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_POWER_ON_HOLD  = 2'd0;
  localparam logic [IDX_W-1:0] REG_POWER_OFF_HOLD = 2'd1;
  localparam logic [IDX_W-1:0] REG_SHUTDOWN_WAIT  = 2'd2;

  // Configuration reset values, in ticks
  localparam logic [CFG_W-1:0] POWER_ON_HOLD_RST  = 16'd1000;
  localparam logic [CFG_W-1:0] POWER_OFF_HOLD_RST = 16'd3000;
  localparam logic [CFG_W-1:0] SHUTDOWN_WAIT_RST  = 16'd10000;

  // Single-bit sequencer state
  typedef struct packed {
    logic on_state;
    logic hold_timing;
    logic shutdown_pending;
    logic shutdown_timing;
    logic regulator_level;
    logic request_level;
  } sps_flags_t;

  // One result transaction
  typedef struct packed {
    logic regulator_on;
    logic shutdown_request;
    logic system_on;
    logic shutting_down;
  } sps_result_t;

endpackage

### rtl/core/sps_step.sv
module sps_step #(
  parameter int TIMER_BITS = 17
) (
  input  sps_pkg::sps_flags_t           flags,
  input  logic [TIMER_BITS-1:0]         hold_elapsed,
  input  logic [TIMER_BITS-1:0]         shutdown_elapsed,
  input  logic                          button_pressed,
  input  logic                          low_voltage,
  input  logic [sps_pkg::CFG_W-1:0]     power_on_hold,
  input  logic [sps_pkg::CFG_W-1:0]     power_off_hold,
  input  logic [sps_pkg::CFG_W-1:0]     shutdown_wait,
  output sps_pkg::sps_flags_t           flags_next,
  output logic [TIMER_BITS-1:0]         hold_elapsed_next,
  output logic [TIMER_BITS-1:0]         shutdown_elapsed_next
);
  import sps_pkg::*;

  // Compare width covers both the counter and the 16-bit registers
  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  logic [TIMER_BITS-1:0] he_inc;
  logic [TIMER_BITS-1:0] se_inc;
  logic                  on_fire;
  logic                  off_fire;
  logic                  sd_fire;

  // Saturating advance of the running timers at the start of the tick
  assign he_inc = !flags.hold_timing ? hold_elapsed :
                  (&hold_elapsed) ? hold_elapsed : hold_elapsed + 1'b1;
  assign se_inc = !flags.shutdown_timing ? shutdown_elapsed :
                  (&shutdown_elapsed) ? shutdown_elapsed : shutdown_elapsed + 1'b1;

  // Threshold compares, strictly greater than the register
  assign on_fire  = CMP_W'(he_inc) > CMP_W'(power_on_hold);
  assign off_fire = CMP_W'(he_inc) > CMP_W'(power_off_hold);
  assign sd_fire  = CMP_W'(se_inc) > CMP_W'(shutdown_wait);

  // Tick sequence: button or shutdown check, then low-voltage shutdown check
  always_comb begin
    flags_next            = flags;
    hold_elapsed_next     = he_inc;
    shutdown_elapsed_next = se_inc;

    if (!flags.shutdown_pending) begin
      if (button_pressed) begin
        if (!flags.hold_timing) begin
          flags_next.hold_timing = 1'b1;
          hold_elapsed_next      = '0;
        end else if (!flags.on_state) begin
          if (on_fire) begin
            flags_next.on_state        = 1'b1;
            flags_next.regulator_level = 1'b1;
            flags_next.hold_timing     = 1'b0;
          end
        end else if (off_fire) begin
          flags_next.on_state         = 1'b0;
          flags_next.request_level    = 1'b1;
          flags_next.hold_timing      = 1'b0;
          flags_next.shutdown_pending = 1'b1;
        end
      end else begin
        flags_next.hold_timing = 1'b0;
      end
    end else begin
      if (!flags.shutdown_timing) begin
        shutdown_elapsed_next       = '0;
        flags_next.shutdown_timing  = 1'b1;
        flags_next.request_level    = 1'b1;
        flags_next.shutdown_pending = 1'b1;
      end else if (sd_fire) begin
        flags_next.regulator_level  = 1'b0;
        flags_next.request_level    = 1'b0;
        flags_next.on_state         = 1'b0;
        flags_next.shutdown_timing  = 1'b0;
        flags_next.shutdown_pending = 1'b0;
      end
    end

    // Second shutdown check; a timer started in this tick sits at zero
    if (low_voltage) begin
      if (!flags_next.shutdown_timing) begin
        shutdown_elapsed_next       = '0;
        flags_next.shutdown_timing  = 1'b1;
        flags_next.request_level    = 1'b1;
        flags_next.shutdown_pending = 1'b1;
      end else if (CMP_W'(shutdown_elapsed_next) > CMP_W'(shutdown_wait)) begin
        flags_next.regulator_level  = 1'b0;
        flags_next.request_level    = 1'b0;
        flags_next.on_state         = 1'b0;
        flags_next.shutdown_timing  = 1'b0;
        flags_next.shutdown_pending = 1'b0;
      end
    end
  end

endmodule

### rtl/core/soft_power_button_sequencer_top.sv
// Path: input transaction into the input register, then sequencer logic into
// the result register. Throughput: one tick per cycle unless out_stall holds
// the result register; the state feeds back through the step logic.
// Reset (rst, synchronous, active high): system off, all timers idle,
// registers back to 1000 / 3000 / 10000 ticks, both pipeline stages empty.
module soft_power_button_sequencer_top #(
  parameter int TIMER_BITS = 17
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write port
  input  logic                      cfg_write,
  input  logic [sps_pkg::IDX_W-1:0] cfg_index,
  input  logic [sps_pkg::CFG_W-1:0] cfg_data,
  // Tick input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      button_pressed,
  input  logic                      low_voltage,
  // Result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      regulator_on,
  output logic                      shutdown_request,
  output logic                      system_on,
  output logic                      shutting_down
);
  import sps_pkg::*;

  logic [CFG_W-1:0]      power_on_hold;
  logic [CFG_W-1:0]      power_off_hold;
  logic [CFG_W-1:0]      shutdown_wait;

  logic                  in_full;
  logic                  in_button;
  logic                  in_lowv;

  sps_flags_t            flags;
  sps_flags_t            flags_next;
  logic [TIMER_BITS-1:0] hold_elapsed;
  logic [TIMER_BITS-1:0] hold_elapsed_next;
  logic [TIMER_BITS-1:0] shutdown_elapsed;
  logic [TIMER_BITS-1:0] shutdown_elapsed_next;

  sps_result_t           result;
  logic                  out_open;
  logic                  advance;
  logic                  in_take;

  // Pipeline handshake
  assign out_open = !out_valid || !out_stall;
  assign advance  = in_full && out_open;
  assign in_stall = in_full && !out_open;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_on_hold  <= POWER_ON_HOLD_RST;
      power_off_hold <= POWER_OFF_HOLD_RST;
      shutdown_wait  <= SHUTDOWN_WAIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_POWER_ON_HOLD:  power_on_hold  <= cfg_data;
        REG_POWER_OFF_HOLD: power_off_hold <= cfg_data;
        REG_SHUTDOWN_WAIT:  shutdown_wait  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_button <= button_pressed;
      in_lowv   <= low_voltage;
    end
  end

  // Sequencer step logic
  sps_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .flags                 (flags),
    .hold_elapsed          (hold_elapsed),
    .shutdown_elapsed      (shutdown_elapsed),
    .button_pressed        (in_button),
    .low_voltage           (in_lowv),
    .power_on_hold         (power_on_hold),
    .power_off_hold        (power_off_hold),
    .shutdown_wait         (shutdown_wait),
    .flags_next            (flags_next),
    .hold_elapsed_next     (hold_elapsed_next),
    .shutdown_elapsed_next (shutdown_elapsed_next)
  );

  // Sequencer state, updated once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      flags            <= '0;
      hold_elapsed     <= '0;
      shutdown_elapsed <= '0;
    end else if (advance) begin
      flags            <= flags_next;
      hold_elapsed     <= hold_elapsed_next;
      shutdown_elapsed <= shutdown_elapsed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_open) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.regulator_on     <= flags_next.regulator_level;
      result.shutdown_request <= flags_next.request_level;
      result.system_on        <= flags_next.on_state;
      result.shutting_down    <= flags_next.shutdown_pending;
    end
  end

  assign regulator_on     = result.regulator_on;
  assign shutdown_request = result.shutdown_request;
  assign system_on        = result.system_on;
  assign shutting_down    = result.shutting_down;

  // The system is never on with the regulator cut
  a_on_has_regulator: assert property (@(posedge clk) disable iff (rst)
    flags.on_state |-> flags.regulator_level)
    else $error("system on without regulator drive");

  // A running shutdown timer always belongs to a pending shutdown
  a_timer_has_pending: assert property (@(posedge clk) disable iff (rst)
    flags.shutdown_timing |-> flags.shutdown_pending)
    else $error("shutdown timer running with no pending shutdown");

  // A tick moved out of the input register shows up as a result
  a_advance_to_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("tick advanced but no result presented");

  // The input side is only held off while the input and result stages are both full
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid))
    else $error("input stalled while pipeline has room");

endmodule

### test/tb_soft_power_button_sequencer_top.sv
`timescale 1ns / 1ps

module tb_soft_power_button_sequencer_top;
  import sps_pkg::*;

  localparam int TIMER_BITS   = 17;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_TICKS = 650;
  localparam int QUIET_TICKS  = 60;
  localparam int PHASES       = 6;

  // Index with no register behind it; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             button;
    logic             lowv;
    bit               known;
    sps_result_t      result;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
  } stim_row_t;

  logic clk;
  logic rst            = 1'b1;
  logic cfg_write      = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic in_valid       = 1'b0;
  logic button_pressed = 1'b0;
  logic low_voltage    = 1'b0;
  logic out_stall      = 1'b0;
  logic in_stall;
  logic out_valid;
  logic regulator_on;
  logic shutdown_request;
  logic system_on;
  logic shutting_down;

  soft_power_button_sequencer_top #(
    .TIMER_BITS(TIMER_BITS)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .button_pressed  (button_pressed),
    .low_voltage     (low_voltage),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .regulator_on    (regulator_on),
    .shutdown_request(shutdown_request),
    .system_on       (system_on),
    .shutting_down   (shutting_down)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sequencer predictor: configuration and state
  logic [CFG_W-1:0] on_hold_ticks  = POWER_ON_HOLD_RST;
  logic [CFG_W-1:0] off_hold_ticks = POWER_OFF_HOLD_RST;
  logic [CFG_W-1:0] shutdown_ticks = SHUTDOWN_WAIT_RST;

  logic                  sys_on     = 1'b0;
  logic                  hold_run   = 1'b0;
  logic [TIMER_BITS-1:0] hold_cnt   = '0;
  logic                  sd_pending = 1'b0;
  logic                  sd_run     = 1'b0;
  logic [TIMER_BITS-1:0] sd_cnt     = '0;
  logic                  reg_drive  = 1'b0;
  logic                  req_drive  = 1'b0;

  sps_result_t pending_results[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned cycles       = 0;
  int unsigned stall_left   = 0;
  bit          quiet        = 1'b0;

  // Elapsed counters stop at all ones
  function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic hold_eval();
    if (!hold_run) begin
      hold_run = 1'b1;
      hold_cnt = '0;
    end else if (!sys_on) begin
      if (hold_cnt > on_hold_ticks) begin
        sys_on    = 1'b1;
        reg_drive = 1'b1;
        hold_run  = 1'b0;
      end
    end else if (hold_cnt > off_hold_ticks) begin
      sys_on     = 1'b0;
      req_drive  = 1'b1;
      hold_run   = 1'b0;
      sd_pending = 1'b1;
    end
  endtask

  task automatic shutdown_eval();
    if (!sd_run) begin
      sd_cnt     = '0;
      sd_run     = 1'b1;
      req_drive  = 1'b1;
      sd_pending = 1'b1;
    end else if (sd_cnt > shutdown_ticks) begin
      reg_drive  = 1'b0;
      req_drive  = 1'b0;
      sys_on     = 1'b0;
      sd_run     = 1'b0;
      sd_pending = 1'b0;
    end
  endtask

  // One tick: counters advance, then button or shutdown check, then low voltage
  task automatic run_tick(input logic b, input logic lv, output sps_result_t r);
    if (hold_run) hold_cnt = bump(hold_cnt);
    if (sd_run) sd_cnt = bump(sd_cnt);
    if (!sd_pending) begin
      if (b) begin
        hold_eval();
      end else begin
        hold_run = 1'b0;
      end
    end else begin
      shutdown_eval();
    end
    if (lv) shutdown_eval();
    r.regulator_on     = reg_drive;
    r.shutdown_request = req_drive;
    r.system_on        = sys_on;
    r.shutting_down    = sd_pending;
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) begin
      note_mismatch($sformatf("result %0d %s got %b expected %b",
                              results_seen, name, got, want));
    end
  endtask

  // Register write, only with nothing in flight
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_POWER_ON_HOLD:  on_hold_ticks  = data;
      REG_POWER_OFF_HOLD: off_hold_ticks = data;
      REG_SHUTDOWN_WAIT:  shutdown_ticks = data;
      default: ;
    endcase
  endtask

  // Send one tick transaction, with an occasional idle burst ahead of it
  task automatic drive_tick(input logic b, input logic lv, input bit known,
                            input sps_result_t typed);
    sps_result_t res;
    cfg_write <= 1'b0;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    button_pressed <= b;
    low_voltage    <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    run_tick(b, lv, res);
    pending_results.push_back(known ? typed : res);
  endtask

  // Mostly small holds so every path fires; now and then the maximum
  function automatic logic [CFG_W-1:0] reg_setting();
    return ($urandom_range(0, 9) == 0) ? {CFG_W{1'b1}} : CFG_W'($urandom_range(0, 12));
  endfunction

  // Result stall: random stall bursts between open stretches
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 19);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_monitor
    sps_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with none expected", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("regulator_on", regulator_on, want.regulator_on);
        check_field("shutdown_request", shutdown_request, want.shutdown_request);
        check_field("system_on", system_on, want.system_on);
        check_field("shutting_down", shutting_down, want.shutting_down);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t directed_rows[$];
    int unsigned sent;
    int unsigned phase_sent;
    int unsigned press_len;
    int unsigned seq_len;
    bit          noise;
    logic        b;
    logic        lv;

    // Directed table: kind, button, low_voltage, known, result, index, data
    // Reset settings: holds far away, low voltage starts a shutdown at once
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b0, 1'b1, 4'b0000, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b1, 4'b0000, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b1, 4'b0000, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b1, 1'b1, 4'b0101, '0, '0});
    // All delays zero: every timer fires on its second check
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_POWER_ON_HOLD, 16'd0});
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_POWER_OFF_HOLD, 16'd0});
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_SHUTDOWN_WAIT, 16'd0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b0, 1'b0, '0, '0, '0});
    // Low voltage twice: shutdown ends and restarts within one tick
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b1, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b1, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b1, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b0, 1'b0, '0, '0, '0});
    // Unused index, then all delays at maximum
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_UNUSED, 16'hFFFF});
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_POWER_ON_HOLD, 16'hFFFF});
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_POWER_OFF_HOLD, 16'hFFFF});
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_SHUTDOWN_WAIT, 16'hFFFF});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b0, 1'b1, 1'b0, '0, '0, '0});
    // Short delays: low voltage lands while the hold timer runs, the hold
    // timer keeps counting and is checked again once the shutdown is over
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_POWER_ON_HOLD, 16'd2});
    directed_rows.push_back('{ROW_WRITE, 1'b0, 1'b0, 1'b0, '0, REG_SHUTDOWN_WAIT, 16'd1});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b1, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});
    directed_rows.push_back('{ROW_TICK,  1'b1, 1'b0, 1'b0, '0, '0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        drive_tick(directed_rows[i].button, directed_rows[i].lowv,
                   directed_rows[i].known, directed_rows[i].result);
      end
    end

    // Random phases: mostly press-and-release sequences, some pure noise
    sent = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_UNUSED, CFG_W'($urandom));
      write_reg(REG_POWER_ON_HOLD, reg_setting());
      write_reg(REG_POWER_OFF_HOLD, reg_setting());
      write_reg(REG_SHUTDOWN_WAIT, reg_setting());
      phase_sent = 0;
      while (phase_sent < RANDOM_TICKS / PHASES) begin
        press_len = $urandom_range(0, 16);
        seq_len   = press_len + $urandom_range(1, 4);
        noise     = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < seq_len; k++) begin
          b  = noise ? 1'($urandom_range(0, 1)) : (k < press_len);
          lv = noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
          drive_tick(b, lv, 1'b0, '0);
          phase_sent++;
          sent++;
          if (sent >= RANDOM_TICKS - QUIET_TICKS) quiet <= 1'b1;
        end
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sps_pkg.sv
rtl/core/sps_step.sv
rtl/core/soft_power_button_sequencer_top.sv
test/tb_soft_power_button_sequencer_top.sv
